/* rtl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and functions of the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 3;
    localparam int unsigned ShiftW = 6;

    // Configuration register indexes.
    localparam logic CFG_MAX_CODE_POINT   = 1'b0;
    localparam logic CFG_REPLACEMENT_CHAR = 1'b1;

    localparam logic [WordW-1:0] MAX_CODE_POINT_RST   = 32'h7FFF_FFFF;
    localparam logic [WordW-1:0] REPLACEMENT_CHAR_RST = 32'h0000_FFFD;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [WordW-1:0]  t_word;
    typedef logic [CountW-1:0] t_count;

    // One accepted input byte as held in the input register.
    typedef struct packed {
        t_byte data_byte;
        logic  end_of_stream;
    } t_in_item;

    // Result of one step: a code point and whether the step produced one.
    typedef struct packed {
        logic  valid;
        t_word code_point;
    } t_step_res;

    // Offset removed from the accumulated value, by count of extra bytes.
    function automatic t_word length_offset(input t_count extra);
        t_word off;
        unique case (extra)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = '0;
        endcase
        return off;
    endfunction

    // Count of extra bytes announced by a lead byte.
    function automatic t_count lead_extra(input t_byte b);
        t_count extra;
        priority if (b < 8'hC0) begin
            extra = 3'd0;
        end else if (b < 8'hE0) begin
            extra = 3'd1;
        end else if (b < 8'hF0) begin
            extra = 3'd2;
        end else if (b < 8'hF8) begin
            extra = 3'd3;
        end else if (b < 8'hFC) begin
            extra = 3'd4;
        end else begin
            extra = 3'd5;
        end
        return extra;
    endfunction

endpackage

/* rtl/u8d_in_reg.sv */
// ----------------------------------------------------------------------------
// u8d_in_reg
// Input register stage: holds one accepted byte until the decode step
// consumes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  u8d_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output u8d_pkg::t_in_item o_item
);

    logic              r_valid;
    u8d_pkg::t_in_item r_item;
    logic              n_valid;

    // A new byte may enter when the register is empty or drains this cycle.
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/u8d_step.sv */
// ----------------------------------------------------------------------------
// u8d_step
// Sequence state and the combinational decode step for one byte.
// ----------------------------------------------------------------------------
module u8d_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  u8d_pkg::t_in_item  i_item,
    input  u8d_pkg::t_word     i_max_code_point,
    input  u8d_pkg::t_word     i_replacement_char,
    output u8d_pkg::t_step_res o_res
);

    u8d_pkg::t_word  r_acc;
    u8d_pkg::t_count r_remaining;
    u8d_pkg::t_count r_seq_extra;
    u8d_pkg::t_word  n_acc;
    u8d_pkg::t_count n_remaining;
    u8d_pkg::t_count n_seq_extra;

    u8d_pkg::t_count lead_cnt;
    u8d_pkg::t_word  byte_word;
    u8d_pkg::t_word  acc_sum;
    u8d_pkg::t_word  fin_value;
    u8d_pkg::t_count fin_extra;
    u8d_pkg::t_word  fin_sub;
    logic            idle;

    assign idle      = (r_remaining == '0);
    assign lead_cnt  = u8d_pkg::lead_extra(i_item.data_byte);
    assign byte_word = {{(u8d_pkg::WordW - u8d_pkg::ByteW){1'b0}}, i_item.data_byte};
    assign acc_sum   = r_acc + byte_word;

    // A lone byte finishes from its own value, the last continuation byte
    // from the running sum.
    assign fin_value = idle ? byte_word : acc_sum;
    assign fin_extra = idle ? '0 : r_seq_extra;
    assign fin_sub   = fin_value - u8d_pkg::length_offset(fin_extra);

    always_comb begin
        o_res.valid      = idle ? (lead_cnt == '0) : (r_remaining == 3'd1);
        o_res.code_point = (fin_sub > i_max_code_point) ? i_replacement_char : fin_sub;
    end

    always_comb begin
        n_acc       = '0;
        n_remaining = '0;
        n_seq_extra = '0;
        if (idle) begin
            if (lead_cnt != '0 && !i_item.end_of_stream) begin
                n_acc       = byte_word << u8d_pkg::ShiftW;
                n_remaining = lead_cnt;
                n_seq_extra = lead_cnt;
            end
        end else if (r_remaining != 3'd1 && !i_item.end_of_stream) begin
            n_acc       = acc_sum << u8d_pkg::ShiftW;
            n_remaining = r_remaining - 3'd1;
            n_seq_extra = r_seq_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_remaining <= '0;
            r_seq_extra <= '0;
        end else if (i_fire) begin
            r_acc       <= n_acc;
            r_remaining <= n_remaining;
            r_seq_extra <= n_seq_extra;
        end
    end

endmodule

/* rtl/u8d_out_reg.sv */
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register: holds one code point until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8d_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  u8d_pkg::t_step_res i_res,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output u8d_pkg::t_word     o_data
);

    logic           r_valid;
    u8d_pkg::t_word r_data;
    logic           n_valid;

    // Room for a new result when empty or when the held one leaves now.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_data <= i_res.code_point;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/utf8_to_utf32_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_unit
// Byte-stream UTF-8 style decoder producing one 32-bit code point for each
// complete sequence, with a programmable limit and replacement value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Contents
//  -------   ---------  ------------------------  ---------------------------
//  s_axis    in         i_s_axis_tvalid/o_..ready  tdata: data_byte[7:0]
//                                                  tlast: end_of_stream
//  m_axis    out        o_m_axis_tvalid/i_..ready  tdata: code_point[31:0]
//  cfg       in         i_cfg_valid/o_cfg_ready    index 0 max_code_point,
//                                                  index 1 replacement_char
//
//  Each byte is held in the input register and is decoded on the way into
//  the result register, which presents the code point once the final byte
//  of its sequence has been decoded.
//  One byte is taken every cycle while the result register is free; the
//  sequence state updates in a single pass per byte, which sets that rate.
//  Reset clears the sequence state, both stage valid flags and restores the
//  two configuration registers. A stalled result register holds the decode
//  stage, and the input register keeps one byte while that lasts.
//
module utf8_to_utf32_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: data_byte[7:0]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    // Output stream. tdata: code_point[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    u8d_pkg::t_in_item  in_item;
    u8d_pkg::t_in_item  held_item;
    u8d_pkg::t_step_res step_res;
    logic               held_valid;
    logic               out_free;
    logic               fire;

    u8d_pkg::t_word r_max_code_point;
    u8d_pkg::t_word r_replacement_char;

    // Configuration writes are always taken; the index selects the register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code_point   <= u8d_pkg::MAX_CODE_POINT_RST;
            r_replacement_char <= u8d_pkg::REPLACEMENT_CHAR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                u8d_pkg::CFG_MAX_CODE_POINT:   r_max_code_point   <= i_cfg_data;
                u8d_pkg::CFG_REPLACEMENT_CHAR: r_replacement_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.data_byte     = i_s_axis_tdata;
    assign in_item.end_of_stream = i_s_axis_tlast;

    // The held byte is decoded whenever the result register can take the
    // outcome, even if that byte produces no code point.
    assign fire = held_valid && out_free;

    u8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (fire),
        .o_item  (held_item)
    );

    u8d_step u_step (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_item             (held_item),
        .i_max_code_point   (r_max_code_point),
        .i_replacement_char (r_replacement_char),
        .o_res              (step_res)
    );

    u8d_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
